FILE: hdl/pcpa_pkg.sv
// Shared types, codes and default sizes for the per-CPU page allocator.
`timescale 1ns / 1ps
`default_nettype none

package pcpa_pkg;

	localparam int NUM_PAGES_DEF = 1024;
	localparam int NUM_CPUS_DEF  = 8;
	localparam int PAGE_BITS_DEF = 12;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_OOM = 2'd1;
	localparam logic [1:0] STAT_BAD = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_RDH,
		ST_LNK,
		ST_POP,
		ST_CHK,
		ST_FWR
	} pcpa_state_t;

endpackage

`default_nettype wire

FILE: hdl/pcpa_link_ram.sv
// Page link memory with a clearing pass that builds the descending reset chain.
`timescale 1ns / 1ps
`default_nettype none

module pcpa_link_ram #(
	parameter int NUM_PAGES = pcpa_pkg::NUM_PAGES_DEF,
	parameter int IDX_W     = $clog2(NUM_PAGES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire logic [IDX_W:0]   wr_data,   // {valid, next page}
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [IDX_W:0]   rd_data,   // {valid, next page}, registered: valid in the cycle after rd_addr
	output logic                  init_done
);

	logic [IDX_W:0]   mem [NUM_PAGES];
	logic [IDX_W-1:0] cnt_q;
	logic             done_q;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W:0]   wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (!done_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == IDX_W'(NUM_PAGES - 1))
				done_q <= 1'b1;
		end
	end

	// page i points at page i-1, page 0 ends the chain
	always_comb begin
		if (!done_q) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = {cnt_q != '0, cnt_q - 1'b1};
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_data <= mem[rd_addr];
	end

	assign init_done = done_q;

endmodule

`default_nettype wire

FILE: hdl/per_cpu_page_allocator.sv
// Top level: per-CPU LIFO free-list page allocator with stealing.
//
// Requests enter on the s_ channel: tuser carries the request type (alloc or
// free), tdata the CPU number and, for a free, the region-relative byte
// address. Exactly one result leaves on the m_ channel per request: tuser is
// the status, tdata the allocated page address and the list it came from.
// One request is in work at a time; s_tready is high only while idle.
// An alloc from the requester's own list passes through ST_RDH, ST_LNK and
// ST_POP; when it must steal, the sequencer first runs ST_SCAN and tests one
// other list per cycle. Out of memory is reported from ST_SCAN once no list
// has a page; a free passes through ST_CHK and ST_FWR, and a rejected free
// ends in ST_CHK. These steps are set by the registered reads of the head
// memory and the link memory, done one after the other, and by the scan.
// After reset the link memory is swept over all NUM_PAGES entries to chain all
// pages onto CPU 0's list, highest first; no request is taken meanwhile.
// A result sits in an output register until taken; if the receiver stalls,
// the next request is still accepted and its work runs up to the point of
// delivering its result, where it waits.
`timescale 1ns / 1ps
`default_nettype none

module per_cpu_page_allocator #(
	parameter int NUM_PAGES = pcpa_pkg::NUM_PAGES_DEF,
	parameter int NUM_CPUS  = pcpa_pkg::NUM_CPUS_DEF,
	parameter int PAGE_BITS = pcpa_pkg::PAGE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // cpu_id[2:0], free_addr[34:3], zero pad
	input  wire logic [0:0]  s_tuser,   // req_type[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // page_addr[31:0], owner_cpu[34:32], zero pad
	output logic      [1:0]  m_tuser    // status[1:0]
);

	localparam int PIDX_W = $clog2(NUM_PAGES);
	localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PA_W   = PIDX_W + PAGE_BITS;
	localparam logic [31:0] OFF_MASK = 32'((64'd1 << PAGE_BITS) - 64'd1);

	pcpa_pkg::pcpa_state_t state_q, state_d;

	logic [CPU_W-1:0]    cpu_q;
	logic [CPU_W-1:0]    cand_q;
	logic [CPU_W-1:0]    target_q;
	logic [31:0]         addr_q;
	logic [NUM_CPUS-1:0] head_valid_q;
	logic                h0_init_q;

	logic [PIDX_W-1:0] head_mem [NUM_CPUS];
	logic [PIDX_W-1:0] hd_rdata_q;
	logic [PIDX_W-1:0] head_eff;

	logic              lk_we;
	logic [PIDX_W-1:0] lk_waddr;
	logic [PIDX_W:0]   lk_wdata;
	logic [PIDX_W:0]   lk_rdata;
	logic              init_done;

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [31:0]       out_addr_q;
	logic [2:0]        out_owner_q;

	logic              accept;
	logic              out_free;
	logic              produce;
	logic [1:0]        res_status;
	logic [31:0]       res_addr;
	logic [2:0]        res_owner;
	logic              hd_we;
	logic [PIDX_W-1:0] hd_wdata;
	logic [CPU_W-1:0]  in_cpu;
	logic [CPU_W-1:0]  cand_next;
	logic [31:0]       fr_shift;
	logic [PIDX_W-1:0] fr_page;
	logic              fr_bad;
	logic [PA_W-1:0]   pa_full;

	function automatic logic [CPU_W-1:0] cpu_wrap(input logic [2:0] id);
		logic [6:0] v;
		v = 7'(id);
		for (int k = 0; k < 8; k++) begin
			if (v >= 7'(NUM_CPUS))
				v = v - 7'(NUM_CPUS);
		end
		return CPU_W'(v);
	endfunction

	function automatic logic [CPU_W-1:0] cpu_inc(input logic [CPU_W-1:0] c);
		if (c == CPU_W'(NUM_CPUS - 1))
			return '0;
		return c + 1'b1;
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign in_cpu   = cpu_wrap(s_tdata[2:0]);
	assign cand_next = cpu_inc(cand_q);

	// CPU 0's head reads as the top page until its entry is first written
	assign head_eff = (h0_init_q && target_q == '0) ? PIDX_W'(NUM_PAGES - 1) : hd_rdata_q;
	assign pa_full  = {head_eff, {PAGE_BITS{1'b0}}};

	assign fr_shift = addr_q >> PAGE_BITS;
	assign fr_page  = PIDX_W'(fr_shift);
	assign fr_bad   = ((addr_q & OFF_MASK) != 32'd0) || (33'(fr_shift) >= 33'(NUM_PAGES));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcpa_pkg::ST_INIT: begin
				if (init_done)
					state_d = pcpa_pkg::ST_IDLE;
			end
			pcpa_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_tuser[0] == pcpa_pkg::REQ_FREE)
						state_d = pcpa_pkg::ST_CHK;
					else if (head_valid_q[in_cpu])
						state_d = pcpa_pkg::ST_RDH;
					else
						state_d = pcpa_pkg::ST_SCAN;
				end
			end
			pcpa_pkg::ST_SCAN: begin
				if (head_valid_q[cand_q])
					state_d = pcpa_pkg::ST_RDH;
				else if (cand_q == cpu_q && out_free)
					state_d = pcpa_pkg::ST_IDLE;
			end
			pcpa_pkg::ST_RDH: state_d = pcpa_pkg::ST_LNK;
			pcpa_pkg::ST_LNK: state_d = pcpa_pkg::ST_POP;
			pcpa_pkg::ST_POP: begin
				if (out_free)
					state_d = pcpa_pkg::ST_IDLE;
			end
			pcpa_pkg::ST_CHK: begin
				if (!fr_bad)
					state_d = pcpa_pkg::ST_FWR;
				else if (out_free)
					state_d = pcpa_pkg::ST_IDLE;
			end
			pcpa_pkg::ST_FWR: begin
				if (out_free)
					state_d = pcpa_pkg::ST_IDLE;
			end
			default: state_d = pcpa_pkg::ST_INIT;
		endcase
	end

	// outputs of the sequencer: results and memory writes
	always_comb begin
		s_tready   = 1'b0;
		produce    = 1'b0;
		res_status = pcpa_pkg::STAT_OK;
		res_addr   = 32'd0;
		res_owner  = 3'd0;
		hd_we      = 1'b0;
		hd_wdata   = lk_rdata[PIDX_W-1:0];
		lk_we      = 1'b0;
		lk_waddr   = fr_page;
		lk_wdata   = {head_valid_q[target_q], head_eff};
		case (state_q)
			pcpa_pkg::ST_IDLE: s_tready = 1'b1;
			pcpa_pkg::ST_SCAN: begin
				if (!head_valid_q[cand_q] && cand_q == cpu_q && out_free) begin
					produce    = 1'b1;
					res_status = pcpa_pkg::STAT_OOM;
				end
			end
			pcpa_pkg::ST_POP: begin
				if (out_free) begin
					produce   = 1'b1;
					res_addr  = 32'(pa_full);
					res_owner = 3'(target_q);
					hd_we     = 1'b1;
				end
			end
			pcpa_pkg::ST_CHK: begin
				if (fr_bad && out_free) begin
					produce    = 1'b1;
					res_status = pcpa_pkg::STAT_BAD;
				end
			end
			pcpa_pkg::ST_FWR: begin
				if (out_free) begin
					produce  = 1'b1;
					hd_we    = 1'b1;
					hd_wdata = fr_page;
					lk_we    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pcpa_pkg::ST_INIT;
			head_valid_q <= NUM_CPUS'(1);
			h0_init_q    <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (hd_we) begin
				head_valid_q[target_q] <= (state_q == pcpa_pkg::ST_FWR) ? 1'b1 : lk_rdata[PIDX_W];
				if (target_q == '0)
					h0_init_q <= 1'b0;
			end
			if (produce)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q    <= in_cpu;
			target_q <= in_cpu;
			cand_q   <= cpu_inc(in_cpu);
			addr_q   <= s_tdata[34:3];
		end else if (state_q == pcpa_pkg::ST_SCAN) begin
			if (head_valid_q[cand_q])
				target_q <= cand_q;
			else if (cand_q != cpu_q)
				cand_q <= cand_next;
		end
		if (produce) begin
			out_status_q <= res_status;
			out_addr_q   <= res_addr;
			out_owner_q  <= res_owner;
		end
	end

	always_ff @(posedge clk) begin
		if (hd_we)
			head_mem[target_q] <= hd_wdata;
		hd_rdata_q <= head_mem[target_q];
	end

	pcpa_link_ram #(
		.NUM_PAGES(NUM_PAGES),
		.IDX_W    (PIDX_W)
	) u_link (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (lk_we),
		.wr_addr  (lk_waddr),
		.wr_data  (lk_wdata),
		.rd_addr  (head_eff),
		.rd_data  (lk_rdata),
		.init_done(init_done)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {5'd0, out_owner_q, out_addr_q};

	a_scan_own_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcpa_pkg::ST_SCAN |-> !head_valid_q[cpu_q])
		else $error("scan running while own list is not empty");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while previous one still in work");

	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pcpa_pkg::STAT_OK |-> m_tdata == 40'd0)
		else $error("failed result carries page data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == pcpa_pkg::STAT_OK || m_tuser == pcpa_pkg::STAT_OOM ||
			m_tuser == pcpa_pkg::STAT_BAD))
		else $error("undefined status code");

endmodule

`default_nettype wire
